[sv/ttrc_pkg.sv]
// ----------------------------------------------------------------------------
// ttrc_pkg
// Shared types, constants and arithmetic helpers for the three-term
// recurrence checksum.
// ----------------------------------------------------------------------------
package ttrc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TERM_W  = 16;
    localparam int unsigned COEF_W  = BYTE_W + 1;
    localparam int unsigned PROD_W  = COEF_W + TERM_W;

    localparam logic [BYTE_W-1:0] ALPHA_STEP   = 8'd17;
    localparam logic [BYTE_W-1:0] BETA_STEP    = 8'd31;
    localparam logic [TERM_W-1:0] FIRST_OFFSET = 16'd7;
    localparam logic [TERM_W-1:0] MOD_FOLD     = 16'hFFFF;
    localparam logic [TERM_W-1:0] TERM_RESET   = 16'd1;
    localparam logic [BYTE_W-1:0] POS_RESET    = 8'd0;
    localparam logic [BYTE_W-1:0] POS_FIRST    = 8'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        logic [TERM_W-1:0] checksum;
        logic              final_res;
    } result_t;

    function automatic logic [BYTE_W-1:0] coef(input logic [BYTE_W-1:0] idx,
                                               input logic [BYTE_W-1:0] step);
        logic [2*BYTE_W-1:0] prod;
        prod = idx * step;
        return prod[BYTE_W-1:0];
    endfunction

    // Reduce mod 65535: 2^16 folds to 1, one correction covers the carry.
    function automatic logic [TERM_W-1:0] fold(input logic [PROD_W-1:0] x);
        logic [TERM_W:0] s;
        s = (TERM_W+1)'(x[PROD_W-1:TERM_W]) + (TERM_W+1)'(x[TERM_W-1:0]);
        if (s >= (TERM_W+1)'(MOD_FOLD))
        begin
            s = s - (TERM_W+1)'(MOD_FOLD);
        end
        return s[TERM_W-1:0];
    endfunction

endpackage

[sv/ttrc_in_stage.sv]
// ----------------------------------------------------------------------------
// ttrc_in_stage
// Input register: captures one word per cycle while in_stall is low and
// holds it until the datapath commits it.
// ----------------------------------------------------------------------------
module ttrc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     data_byte,
    input  logic           first_byte,
    input  logic           last_byte,
    input  logic           ready,
    output logic           item_valid,
    output ttrc_pkg::item_t item
);
    import ttrc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign in_stall   = valid_reg && !ready;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= '{data_byte: data_byte, first_byte: first_byte,
                          last_byte: last_byte};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/ttrc_datapath.sv]
// ----------------------------------------------------------------------------
// ttrc_datapath
// Recurrence state and the combinational term update: two small products,
// a signed difference and a mod-65535 fold.
// ----------------------------------------------------------------------------
module ttrc_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              commit,
    input  ttrc_pkg::item_t   item,
    output ttrc_pkg::result_t result
);
    import ttrc_pkg::*;

    logic [TERM_W-1:0] older_reg;
    logic [TERM_W-1:0] older_next;
    logic [TERM_W-1:0] newer_reg;
    logic [TERM_W-1:0] newer_next;
    logic [BYTE_W-1:0] position_reg;
    logic [BYTE_W-1:0] position_next;

    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] beta;
    logic [COEF_W-1:0] a_coef;
    logic [PROD_W-1:0] term_a;
    logic [PROD_W-1:0] term_b;
    logic              negative;
    logic [PROD_W-1:0] fold_in;
    logic [TERM_W-1:0] fold_out;
    logic [TERM_W-1:0] rec_sum;
    logic [TERM_W-1:0] sum;

    always_comb
    begin
        alpha    = coef(position_reg, ALPHA_STEP);
        beta     = coef(position_reg, BETA_STEP);
        a_coef   = COEF_W'(item.data_byte) + COEF_W'(alpha);
        term_a   = PROD_W'(a_coef) * PROD_W'(newer_reg);
        term_b   = PROD_W'(beta) * PROD_W'(older_reg);
        negative = term_a < term_b;
        // A negative difference of magnitude d lands on (1 - d) mod 65535.
        fold_in  = negative ? (term_b - term_a - PROD_W'(1)) : (term_a - term_b);
        fold_out = fold(fold_in);
        if (negative)
        begin
            rec_sum = (fold_out == '0) ? '0 : (MOD_FOLD - fold_out);
        end
        else
        begin
            rec_sum = fold_out;
        end

        if (item.first_byte)
        begin
            sum           = TERM_W'(item.data_byte) + FIRST_OFFSET;
            older_next    = TERM_RESET;
            position_next = POS_FIRST;
        end
        else
        begin
            sum           = rec_sum;
            older_next    = newer_reg;
            position_next = position_reg + BYTE_W'(1);
        end
        newer_next = sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg    <= TERM_RESET;
            newer_reg    <= TERM_RESET;
            position_reg <= POS_RESET;
        end
        else if (commit)
        begin
            older_reg    <= older_next;
            newer_reg    <= newer_next;
            position_reg <= position_next;
        end
    end

    assign result = '{checksum: sum, final_res: item.last_byte};

    a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
        commit && item.first_byte |=> position_reg == POS_FIRST && older_reg == TERM_RESET)
        else $error("first word did not restart the recurrence");

    a_shift_terms: assert property (@(posedge clk) disable iff (!rst_n)
        commit && !item.first_byte |=> older_reg == $past(newer_reg))
        else $error("older term not taken from newer term");

    a_newer_is_sum: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> newer_reg == $past(result.checksum))
        else $error("newer term differs from delivered checksum");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(newer_reg) && $stable(older_reg) && $stable(position_reg))
        else $error("state moved without a commit");

endmodule

[sv/ttrc_out_stage.sv]
// ----------------------------------------------------------------------------
// ttrc_out_stage
// Result register: holds a finished checksum until the sink takes it and
// tells the input side when a new word may advance.
// ----------------------------------------------------------------------------
module ttrc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  ttrc_pkg::result_t result,
    output logic              ready,
    output logic              commit,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [15:0]       checksum,
    output logic              final_res
);
    import ttrc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign ready      = !valid_reg || !out_stall;
    assign commit     = item_valid && ready;
    assign valid_next = ready ? item_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign checksum  = result_reg.checksum;
    assign final_res = result_reg.final_res;

endmodule

[sv/three_term_recurrence_checksum.sv]
// ----------------------------------------------------------------------------
// three_term_recurrence_checksum
// Path: an accepted word passes the input register, then the result
// register; a stall on the output can hold it in either register.
// Throughput: 1 word per cycle while the output does not stall; the term
// update is combinational from the input register to the result register.
// Reset: asynchronous, active low; empties both registers, sets both terms
// to 1 and the position to 0.
// ----------------------------------------------------------------------------
module three_term_recurrence_checksum (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] checksum,
    output logic        final_res
);
    import ttrc_pkg::*;

    logic    ready;
    logic    commit;
    logic    item_valid;
    item_t   item;
    result_t result;

    ttrc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .ready      (ready),
        .item_valid (item_valid),
        .item       (item)
    );

    ttrc_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .item   (item),
        .result (result)
    );

    ttrc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .ready      (ready),
        .commit     (commit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .checksum   (checksum),
        .final_res  (final_res)
    );

endmodule

[tb/three_term_recurrence_checksum_tb.sv]
// ----------------------------------------------------------------------------
// three_term_recurrence_checksum_tb
// Drives byte streams into the recurrence checksum block: a short directed
// run of edge cases, then well-formed messages (one of them long enough to
// wrap the byte index) mixed with streams of random framing flags. The sender
// runs in bursts with random gaps and the receiver stalls in changing
// patterns. A scoreboard keeps its own copy of the two terms and the index,
// predicts each running checksum, and checks results in order.
// ----------------------------------------------------------------------------
module three_term_recurrence_checksum_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ttrc_pkg::*;

    localparam int unsigned WORD_TARGET = 800;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    class checksum_scoreboard;
        logic [TERM_W-1:0] prev_term;
        logic [TERM_W-1:0] cur_term;
        logic [BYTE_W-1:0] byte_index;
        result_t           expected_sums[$];
        int unsigned       errors;

        function new();
            prev_term  = TERM_RESET;
            cur_term   = TERM_RESET;
            byte_index = POS_RESET;
            errors     = 0;
        endfunction

        function logic [TERM_W-1:0] next_checksum(logic [BYTE_W-1:0] b);
            longint unsigned coef_a;
            longint unsigned coef_b;
            longint unsigned lhs;
            longint unsigned rhs;
            longint unsigned diff;
            longint unsigned modulus;
            modulus = 64'(MOD_FOLD);
            coef_a  = (64'(byte_index) * 64'(ALPHA_STEP)) & 64'hFF;
            coef_b  = (64'(byte_index) * 64'(BETA_STEP)) & 64'hFF;
            lhs     = (64'(b) + coef_a) * 64'(cur_term);
            rhs     = coef_b * 64'(prev_term);
            if (lhs >= rhs)
            begin
                return TERM_W'((lhs - rhs) % modulus);
            end
            diff = rhs - lhs;
            return TERM_W'((modulus - ((diff - 1) % modulus)) % modulus);
        endfunction

        function void note_input(logic [BYTE_W-1:0] b, logic first, logic last);
            result_t exp_word;
            if (first)
            begin
                prev_term  = TERM_RESET;
                cur_term   = TERM_W'(b) + FIRST_OFFSET;
                byte_index = POS_FIRST;
            end
            else
            begin
                exp_word.checksum = next_checksum(b);
                prev_term  = cur_term;
                cur_term   = exp_word.checksum;
                byte_index = byte_index + 1'b1;
            end
            exp_word.checksum  = cur_term;
            exp_word.final_res = last;
            expected_sums.push_back(exp_word);
        endfunction

        function void check_result(logic [TERM_W-1:0] sum, logic fin);
            result_t exp_word;
            if (expected_sums.size() == 0)
            begin
                $display("%0t: unexpected result: expected none actual checksum %h final %b",
                         $time, sum, fin);
                errors++;
                return;
            end
            exp_word = expected_sums.pop_front();
            if (sum !== exp_word.checksum)
            begin
                $display("%0t: checksum mismatch: expected %h actual %h",
                         $time, exp_word.checksum, sum);
                errors++;
            end
            if (fin !== exp_word.final_res)
            begin
                $display("%0t: final_res mismatch: expected %b actual %b",
                         $time, exp_word.final_res, fin);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_sums.size();
        endfunction
    endclass

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [7:0]        data_byte  = 8'h00;
    logic              first_byte = 1'b0;
    logic              last_byte  = 1'b0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [15:0]       checksum;
    logic              final_res;

    checksum_scoreboard sb;
    int unsigned        words_sent;
    int unsigned        burst_left;
    int unsigned        cycle_count;
    int unsigned        stall_tick;
    stall_mode_t        stall_mode;

    three_term_recurrence_checksum dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .checksum   (checksum),
        .final_res  (final_res)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(logic [7:0] b, logic first, logic last);
        in_valid   <= 1'b1;
        data_byte  <= b;
        first_byte <= first;
        last_byte  <= last;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_input(b, first, last);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic idle_cycles(int unsigned n);
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic take_gap();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5));
        end
        burst_left--;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic send_message(int unsigned len, bit well_formed);
        logic first;
        logic last;
        for (int unsigned k = 0; k < len; k++)
        begin
            if (well_formed)
            begin
                first = (k == 0);
                last  = (k == len - 1);
            end
            else
            begin
                first = ($urandom_range(0, 5) == 0);
                last  = ($urandom_range(0, 5) == 0);
            end
            take_gap();
            send_word(8'($urandom_range(0, 255)), first, last);
        end
    endtask

    // Receiver: switch stall pattern every so often, including no stall at all.
    always @(negedge clk)
    begin
        stall_tick++;
        if (stall_tick % 97 == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
        end
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
            STALL_PERIODIC: out_stall <= (stall_tick % 3 == 0);
            default:        out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(checksum, final_res);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        sb          = new();
        words_sent  = 0;
        burst_left  = 0;
        cycle_count = 0;
        stall_tick  = 0;
        stall_mode  = STALL_NONE;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // bytes before any first byte, then continuing after a last byte
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'h3C, 1'b0, 1'b0);
        // first and last on one byte
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b0);
        // extremes inside framed messages
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h80, 1'b0, 1'b0);
        send_word(8'h01, 1'b0, 1'b1);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h7F, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h55, 1'b0, 1'b1);
        send_word(8'hAA, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        drain();

        // long message to wrap the byte index
        send_message(300, 1'b1);
        drain();

        while (words_sent < WORD_TARGET)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                send_message(($urandom_range(0, 9) == 0) ? $urandom_range(200, 290)
                                                         : $urandom_range(1, 16), 1'b1);
            end
            else
            begin
                send_message($urandom_range(1, 12), 1'b0);
            end
        end
        drain();
        repeat (10) @(negedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[three_term_recurrence_checksum.f]
sv/ttrc_pkg.sv
sv/ttrc_in_stage.sv
sv/ttrc_datapath.sv
sv/ttrc_out_stage.sv
sv/three_term_recurrence_checksum.sv
tb/three_term_recurrence_checksum_tb.sv
